[hw/rtl/cdpt_pkg.sv]
package cdpt_pkg;

    localparam int RANK_COUNT = 13;
    localparam int SUIT_TOTAL = 4;
    localparam int DECK_SIZE  = 52;

    // cards that init places: a full set, clipped to the table depth
    localparam int FILL_COUNT = (RANK_COUNT * SUIT_TOTAL < DECK_SIZE) ?
                                (RANK_COUNT * SUIT_TOTAL) : DECK_SIZE;

    localparam int CMD_W  = 2;
    localparam int RANK_W = 4;
    localparam int SUIT_W = 2;
    localparam int CARD_W = RANK_W + SUIT_W;
    localparam int RND_W  = 31;
    localparam int LEFT_W = 6;
    localparam int IDX_W  = (DECK_SIZE > 1) ? $clog2(DECK_SIZE) : 1;
    localparam int CNT_W  = $clog2(DECK_SIZE + 1);

    localparam logic [CMD_W-1:0] CMD_INIT    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DRAW    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_SHUFFLE = 2'd3;

    typedef logic [CARD_W-1:0] card_t;

    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic [SUIT_W-1:0] suit;
        logic              found;
        logic              empty;
        logic              done;
    } res_t;

endpackage

[hw/rtl/cdpt_if.sv]
interface cdpt_in_if import cdpt_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [RANK_W-1:0] want_rank;
    logic [SUIT_W-1:0] want_suit;
    logic [RND_W-1:0]  random_word;

    modport source (output valid, output cmd, output want_rank, output want_suit,
                    output random_word, input ready);
    modport sink (input valid, input cmd, input want_rank, input want_suit,
                  input random_word, output ready);
endinterface

interface cdpt_out_if import cdpt_pkg::*;;
    logic              valid;
    logic              ready;
    logic [RANK_W-1:0] card_rank;
    logic [SUIT_W-1:0] card_suit;
    logic              found;
    logic              deck_empty;
    logic              shuffle_done;
    logic [LEFT_W-1:0] cards_left;

    modport source (output valid, output card_rank, output card_suit, output found,
                    output deck_empty, output shuffle_done, output cards_left,
                    input ready);
    modport sink (input valid, input card_rank, input card_suit, input found,
                  input deck_empty, input shuffle_done, input cards_left,
                  output ready);
endinterface

[hw/rtl/cdpt_ram.sv]
module cdpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hw/rtl/cdpt_mod.sv]
module cdpt_mod import cdpt_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [RND_W-1:0] dividend,
    input  logic [CNT_W-1:0] divisor,
    output logic             done,
    output logic [CNT_W-1:0] remainder
);

    localparam int STEP_W = $clog2(RND_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [RND_W-1:0]  dvd_reg, dvd_next;
    logic [CNT_W-1:0]  div_reg, div_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W:0]    trial;

    // restoring reduction, one dividend bit per cycle
    assign trial = {rem_reg, dvd_reg[RND_W-1]};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            dvd_next  = dividend;
            div_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = CNT_W'(trial - {1'b0, div_reg});
            end
            else
            begin
                rem_next = trial[CNT_W-1:0];
            end
            dvd_next  = {dvd_reg[RND_W-2:0], 1'b0};
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(RND_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

[hw/rtl/card_deck_permutation_table.sv]
// Card table with four commands: init, remove, draw and one shuffle swap. One item is
// worked at a time, and ready is low until its result has moved into the output register,
// which then waits for the sink while the next item is taken. The memory has one write port
// and one read port with registered read. Init writes FILL_COUNT entries; remove reads the
// entries in turn until a hit and then shifts each later entry down by one; draw reads one
// entry, and none when the deck is empty; a shuffle swap runs a bit-serial modulo reduction,
// then two reads and two writes, and skips all of it when the table holds fewer than two
// cards. No memory clearing after reset.
module card_deck_permutation_table import cdpt_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    cdpt_in_if.sink     req,
    cdpt_out_if.source  rsp
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_INIT     = 4'd1;
    localparam logic [3:0] S_SRCH_RD  = 4'd2;
    localparam logic [3:0] S_SRCH_CMP = 4'd3;
    localparam logic [3:0] S_SHF_RD   = 4'd4;
    localparam logic [3:0] S_SHF_WR   = 4'd5;
    localparam logic [3:0] S_DRAW_RD  = 4'd6;
    localparam logic [3:0] S_DRAW_DAT = 4'd7;
    localparam logic [3:0] S_MOD      = 4'd8;
    localparam logic [3:0] S_SW_RDI   = 4'd9;
    localparam logic [3:0] S_SW_RDJ   = 4'd10;
    localparam logic [3:0] S_SW_WRI   = 4'd11;
    localparam logic [3:0] S_SW_WRJ   = 4'd12;
    localparam logic [3:0] S_DONE     = 4'd13;

    logic [3:0]        state_reg, state_next;
    logic [CNT_W-1:0]  total_reg, total_next;
    logic [CNT_W-1:0]  dp_reg, dp_next;
    logic [CNT_W-1:0]  sp_reg, sp_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  jdx_reg, jdx_next;
    logic [RANK_W-1:0] rank_reg, rank_next;
    logic [SUIT_W-1:0] suit_reg, suit_next;
    card_t             want_reg, want_next;
    card_t             tmp_reg, tmp_next;
    res_t              res_reg, res_next;
    res_t              out_reg, out_next;
    logic [LEFT_W-1:0] left_reg, left_next;
    logic              out_valid_reg, out_valid_next;

    logic              accept;
    logic [CNT_W-1:0]  idx_inc;
    logic [CNT_W-1:0]  swap_pos;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [IDX_W-1:0]  mem_raddr;
    card_t             mem_wdata;
    card_t             mem_rdata;
    logic              mod_start;
    logic              mod_done;
    logic [CNT_W-1:0]  mod_rem;

    assign accept  = req.valid && req.ready;
    assign idx_inc = CNT_W'(idx_reg) + CNT_W'(1);

    // a pass starts at the top, or restarts lower when removals shrank the deck
    assign swap_pos = (sp_reg == '0 || sp_reg >= total_reg) ?
                      (total_reg - CNT_W'(1)) : sp_reg;

    assign mod_start = accept && (req.cmd == CMD_SHUFFLE) && (total_reg > CNT_W'(1));

    cdpt_ram #(
        .WIDTH (CARD_W),
        .DEPTH (DECK_SIZE)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    cdpt_mod u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (req.random_word),
        .divisor   (swap_pos + CNT_W'(1)),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    always_comb
    begin
        state_next     = state_reg;
        total_next     = total_reg;
        dp_next        = dp_reg;
        sp_next        = sp_reg;
        idx_next       = idx_reg;
        jdx_next       = jdx_reg;
        rank_next      = rank_reg;
        suit_next      = suit_reg;
        want_next      = want_reg;
        tmp_next       = tmp_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        left_next      = left_reg;
        out_valid_next = out_valid_reg;
        mem_we         = 1'b0;
        mem_waddr      = idx_reg;
        mem_wdata      = {suit_reg, rank_reg};
        mem_raddr      = idx_reg;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_next  = '0;
                    idx_next  = '0;
                    rank_next = '0;
                    suit_next = '0;
                    want_next = {req.want_suit, req.want_rank};
                    case (req.cmd)
                        CMD_INIT:
                        begin
                            state_next = S_INIT;
                        end
                        CMD_REMOVE:
                        begin
                            state_next = (total_reg == '0) ? S_DONE : S_SRCH_RD;
                        end
                        CMD_DRAW:
                        begin
                            if (dp_reg >= total_reg)
                            begin
                                res_next.empty = 1'b1;
                                state_next     = S_DONE;
                            end
                            else
                            begin
                                state_next = S_DRAW_RD;
                            end
                        end
                        default:
                        begin
                            if (total_reg <= CNT_W'(1))
                            begin
                                sp_next       = '0;
                                dp_next       = '0;
                                res_next.done = 1'b1;
                                state_next    = S_DONE;
                            end
                            else
                            begin
                                idx_next   = swap_pos[IDX_W-1:0];
                                state_next = S_MOD;
                            end
                        end
                    endcase
                end
            end

            S_INIT:
            begin
                mem_we = 1'b1;
                if (idx_inc == CNT_W'(FILL_COUNT))
                begin
                    total_next = CNT_W'(FILL_COUNT);
                    dp_next    = '0;
                    sp_next    = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next = idx_inc[IDX_W-1:0];
                    if (rank_reg == RANK_W'(RANK_COUNT - 1))
                    begin
                        rank_next = '0;
                        suit_next = suit_reg + SUIT_W'(1);
                    end
                    else
                    begin
                        rank_next = rank_reg + RANK_W'(1);
                    end
                end
            end

            S_SRCH_RD:
            begin
                state_next = S_SRCH_CMP;
            end

            S_SRCH_CMP:
            begin
                if (mem_rdata == want_reg)
                begin
                    res_next.found = 1'b1;
                    if (idx_inc < total_reg)
                    begin
                        idx_next   = idx_inc[IDX_W-1:0];
                        state_next = S_SHF_RD;
                    end
                    else
                    begin
                        total_next = total_reg - CNT_W'(1);
                        state_next = S_DONE;
                    end
                end
                else if (idx_inc < total_reg)
                begin
                    idx_next   = idx_inc[IDX_W-1:0];
                    state_next = S_SRCH_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_SHF_RD:
            begin
                state_next = S_SHF_WR;
            end

            S_SHF_WR:
            begin
                // entry k moves down to k-1
                mem_we    = 1'b1;
                mem_waddr = idx_reg - IDX_W'(1);
                mem_wdata = mem_rdata;
                if (idx_inc < total_reg)
                begin
                    idx_next   = idx_inc[IDX_W-1:0];
                    state_next = S_SHF_RD;
                end
                else
                begin
                    total_next = total_reg - CNT_W'(1);
                    state_next = S_DONE;
                end
            end

            S_DRAW_RD:
            begin
                mem_raddr  = dp_reg[IDX_W-1:0];
                state_next = S_DRAW_DAT;
            end

            S_DRAW_DAT:
            begin
                res_next.rank = mem_rdata[RANK_W-1:0];
                res_next.suit = mem_rdata[CARD_W-1:RANK_W];
                dp_next       = dp_reg + CNT_W'(1);
                state_next    = S_DONE;
            end

            S_MOD:
            begin
                if (mod_done)
                begin
                    jdx_next   = mod_rem[IDX_W-1:0];
                    state_next = S_SW_RDI;
                end
            end

            S_SW_RDI:
            begin
                state_next = S_SW_RDJ;
            end

            S_SW_RDJ:
            begin
                mem_raddr  = jdx_reg;
                tmp_next   = mem_rdata;
                state_next = S_SW_WRI;
            end

            S_SW_WRI:
            begin
                mem_we     = 1'b1;
                mem_wdata  = mem_rdata;
                state_next = S_SW_WRJ;
            end

            S_SW_WRJ:
            begin
                mem_we    = 1'b1;
                mem_waddr = jdx_reg;
                mem_wdata = tmp_reg;
                sp_next   = CNT_W'(idx_reg) - CNT_W'(1);
                if (idx_reg == IDX_W'(1))
                begin
                    dp_next       = '0;
                    res_next.done = 1'b1;
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_next       = res_reg;
                    left_next      = LEFT_W'(total_reg);
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            total_reg     <= '0;
            dp_reg        <= '0;
            sp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            dp_reg        <= dp_next;
            sp_reg        <= sp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        jdx_reg  <= jdx_next;
        rank_reg <= rank_next;
        suit_reg <= suit_next;
        want_reg <= want_next;
        tmp_reg  <= tmp_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
        left_reg <= left_next;
    end

    assign req.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = out_valid_reg;
    assign rsp.card_rank    = out_reg.rank;
    assign rsp.card_suit    = out_reg.suit;
    assign rsp.found        = out_reg.found;
    assign rsp.deck_empty   = out_reg.empty;
    assign rsp.shuffle_done = out_reg.done;
    assign rsp.cards_left   = left_reg;

endmodule

[verif/testbench.sv]
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import cdpt_pkg::*;

    localparam int ITEM_TARGET  = 900;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 250;
    localparam int DIRECTED_ROWS = 21;

    localparam logic [LEFT_W-1:0] FULL_LEFT = LEFT_W'(FILL_COUNT);
    localparam logic [RND_W-1:0]  WORD_ONES = '1;

    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic [SUIT_W-1:0] suit;
        logic              found;
        logic              empty;
        logic              done;
        logic [LEFT_W-1:0] left;
    } outcome_t;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [RANK_W-1:0] rank;
        logic [SUIT_W-1:0] suit;
        logic [RND_W-1:0]  word;
        logic              typed;
        outcome_t          want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;

    cdpt_in_if  req_if ();
    cdpt_out_if rsp_if ();

    card_deck_permutation_table uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // shadow of the card table
    card_t deck_mem [DECK_SIZE];
    int    shadow_total = 0;
    int    draw_idx   = 0;
    int    swap_pos   = 0;

    outcome_t  pending_results [$];
    stim_row_t directed_rows [DIRECTED_ROWS];

    int items_sent     = 0;
    int results_seen   = 0;
    int remove_hits    = 0;
    int passes_closed  = 0;
    int empty_draws    = 0;
    int errors         = 0;
    int cycles         = 0;

    function automatic outcome_t deck_predict(input logic [CMD_W-1:0] cmd,
                                              input logic [RANK_W-1:0] rank,
                                              input logic [SUIT_W-1:0] suit,
                                              input logic [RND_W-1:0] word);
        outcome_t o;
        card_t    want;
        card_t    held;
        int       hit_at;
        int       pos;
        int       j;
        o = '0;
        case (cmd)
            CMD_INIT:
            begin
                shadow_total = 0;
                for (int s = 0; s < SUIT_TOTAL; s++)
                begin
                    for (int r = 0; r < RANK_COUNT; r++)
                    begin
                        if (shadow_total < DECK_SIZE)
                        begin
                            deck_mem[shadow_total] = {SUIT_W'(s), RANK_W'(r)};
                            shadow_total++;
                        end
                    end
                end
                draw_idx = 0;
                swap_pos = 0;
            end
            CMD_REMOVE:
            begin
                want   = {suit, rank};
                hit_at = shadow_total;
                for (int i = 0; i < shadow_total; i++)
                begin
                    if (hit_at == shadow_total && deck_mem[i] == want)
                        hit_at = i;
                end
                if (hit_at < shadow_total)
                begin
                    for (int k = hit_at + 1; k < shadow_total; k++)
                        deck_mem[k-1] = deck_mem[k];
                    shadow_total--;
                    o.found = 1'b1;
                end
            end
            CMD_DRAW:
            begin
                if (draw_idx >= shadow_total)
                    o.empty = 1'b1;
                else
                begin
                    o.rank = deck_mem[draw_idx][RANK_W-1:0];
                    o.suit = deck_mem[draw_idx][CARD_W-1:RANK_W];
                    draw_idx++;
                end
            end
            CMD_SHUFFLE:
            begin
                if (shadow_total <= 1)
                begin
                    swap_pos = 0;
                    draw_idx = 0;
                    o.done   = 1'b1;
                end
                else
                begin
                    // new pass, or the deck shrank under the current position
                    if (swap_pos == 0 || swap_pos >= shadow_total)
                        swap_pos = shadow_total - 1;
                    pos = swap_pos;
                    j   = int'(32'(word) % 32'(pos + 1));
                    held          = deck_mem[pos];
                    deck_mem[pos] = deck_mem[j];
                    deck_mem[j]   = held;
                    swap_pos = pos - 1;
                    if (swap_pos == 0)
                    begin
                        draw_idx = 0;
                        o.done   = 1'b1;
                    end
                end
            end
        endcase
        o.left = LEFT_W'(shadow_total);
        return o;
    endfunction

    // 0 and 4: no idling, 1: sender gaps, 2: receiver stalls, 3: both
    function automatic int stall_pct(input bit receiver);
        case ((items_sent / 120) % 5)
            1:       return receiver ? 0 : 55;
            2:       return receiver ? 55 : 0;
            3:       return 33;
            default: return 0;
        endcase
    endfunction

    function automatic logic [RND_W-1:0] rnd_word();
        logic [31:0] raw;
        raw = $urandom;
        case ($urandom_range(0, 7))
            0:       return WORD_ONES;
            1:       return '0;
            2:       return RND_W'($urandom_range(0, 63));
            default: return raw[RND_W-1:0];
        endcase
    endfunction

    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [RANK_W-1:0] rank,
                             input logic [SUIT_W-1:0] suit, input logic [RND_W-1:0] word,
                             input logic typed, input outcome_t want);
        outcome_t predicted;
        @(negedge clk);
        while ($urandom_range(0, 99) < stall_pct(1'b0))
        begin
            req_if.valid = 1'b0;
            @(negedge clk);
        end
        req_if.valid       = 1'b1;
        req_if.cmd         = cmd;
        req_if.want_rank   = rank;
        req_if.want_suit   = suit;
        req_if.random_word = word;
        do
            @(posedge clk);
        while (!req_if.ready);
        predicted = deck_predict(cmd, rank, suit, word);
        pending_results.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    task automatic issue(input logic [CMD_W-1:0] cmd, input logic [RANK_W-1:0] rank,
                         input logic [SUIT_W-1:0] suit);
        send_item(cmd, rank, suit, rnd_word(), 1'b0, '0);
    endtask

    task automatic issue_noise(input logic [CMD_W-1:0] cmd);
        issue(cmd, RANK_W'($urandom_range(0, 15)), SUIT_W'($urandom_range(0, 3)));
    endtask

    // remove a card that is known to be in the table
    task automatic remove_present();
        card_t c;
        c = deck_mem[$urandom_range(0, shadow_total - 1)];
        issue(CMD_REMOVE, c[RANK_W-1:0], c[CARD_W-1:RANK_W]);
    endtask

    task automatic wait_quiet();
        @(negedge clk);
        req_if.valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic run_random();
        int kind;
        int n;
        int target;
        while (items_sent < ITEM_TARGET)
        begin
            kind = $urandom_range(0, 9);
            if ($urandom_range(0, 9) == 0)
                wait_quiet();
            if ($urandom_range(0, 1) == 0 || shadow_total < 2)
                issue_noise(CMD_INIT);
            if (kind <= 3)
            begin
                // one whole shuffle pass, with a few draws and removals mixed in
                issue_noise(CMD_SHUFFLE);
                while (swap_pos != 0)
                begin
                    n = $urandom_range(0, 19);
                    if (n == 0)
                        issue_noise(CMD_DRAW);
                    else if (n == 1 && shadow_total > 0)
                        remove_present();
                    else
                        issue_noise(CMD_SHUFFLE);
                end
                n = $urandom_range(0, 12);
                repeat (n) issue_noise(CMD_DRAW);
            end
            else if (kind <= 5)
            begin
                // thin the deck out, down to empty or a single card at times
                target = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1)
                                                     : $urandom_range(2, 40);
                while (shadow_total > target)
                begin
                    if ($urandom_range(0, 7) == 0)
                        issue_noise(CMD_REMOVE);
                    else
                        remove_present();
                end
                n = $urandom_range(1, 6);
                repeat (n)
                begin
                    if ($urandom_range(0, 2) == 0)
                        issue_noise(CMD_DRAW);
                    else
                        issue_noise(CMD_SHUFFLE);
                end
                while (draw_idx < shadow_total)
                    issue_noise(CMD_DRAW);
                issue_noise(CMD_DRAW);
            end
            else if (kind == 6)
            begin
                while (draw_idx < shadow_total)
                    issue_noise(CMD_DRAW);
                repeat (2) issue_noise(CMD_DRAW);
            end
            else
            begin
                repeat (20) issue_noise(CMD_W'($urandom_range(0, 3)));
            end
        end
    endtask

    function automatic void cmp_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            errors++;
            $display("%0t ns: %s expected %0d actual %0d", $time, name, exp_v, act_v);
        end
    endfunction

    always @(posedge clk)
    begin
        outcome_t exp_o;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t ns: result with nothing outstanding, expected none actual %0d/%0d",
                         $time, rsp_if.card_rank, rsp_if.cards_left);
            end
            else
            begin
                exp_o = pending_results.pop_front();
                results_seen++;
                remove_hits   += exp_o.found;
                passes_closed += exp_o.done;
                empty_draws   += exp_o.empty;
                cmp_field("card_rank", 32'(exp_o.rank), 32'(rsp_if.card_rank));
                cmp_field("card_suit", 32'(exp_o.suit), 32'(rsp_if.card_suit));
                cmp_field("found", 32'(exp_o.found), 32'(rsp_if.found));
                cmp_field("deck_empty", 32'(exp_o.empty), 32'(rsp_if.deck_empty));
                cmp_field("shuffle_done", 32'(exp_o.done), 32'(rsp_if.shuffle_done));
                cmp_field("cards_left", 32'(exp_o.left), 32'(rsp_if.cards_left));
            end
        end
    end

    always @(negedge clk)
        rsp_if.ready = !($urandom_range(0, 99) < stall_pct(1'b1));

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        req_if.valid       = 1'b0;
        req_if.cmd         = CMD_INIT;
        req_if.want_rank   = '0;
        req_if.want_suit   = '0;
        req_if.random_word = '0;
        rsp_if.ready       = 1'b0;
        rst_n              = 1'b0;

        // typed rows carry their expected result, the rest go through the predictor
        directed_rows = '{
            '{CMD_DRAW,    4'd0,  2'd0, 31'd0,        1'b1,
              '{4'd0, 2'd0, 1'b0, 1'b1, 1'b0, 6'd0}},
            '{CMD_REMOVE,  4'd0,  2'd0, 31'd0,        1'b1,
              '{4'd0, 2'd0, 1'b0, 1'b0, 1'b0, 6'd0}},
            '{CMD_SHUFFLE, 4'd0,  2'd0, WORD_ONES,    1'b1,
              '{4'd0, 2'd0, 1'b0, 1'b0, 1'b1, 6'd0}},
            '{CMD_INIT,    4'd15, 2'd3, WORD_ONES,    1'b1,
              '{4'd0, 2'd0, 1'b0, 1'b0, 1'b0, FULL_LEFT}},
            '{CMD_DRAW,    4'd0,  2'd0, 31'd0,        1'b1,
              '{4'd0, 2'd0, 1'b0, 1'b0, 1'b0, FULL_LEFT}},
            '{CMD_DRAW,    4'd0,  2'd0, 31'd0,        1'b1,
              '{4'd1, 2'd0, 1'b0, 1'b0, 1'b0, FULL_LEFT}},
            '{CMD_REMOVE,  4'd12, 2'd3, 31'd0,        1'b1,
              '{4'd0, 2'd0, 1'b1, 1'b0, 1'b0, FULL_LEFT - 6'd1}},
            '{CMD_REMOVE,  4'd12, 2'd3, 31'd0,        1'b1,
              '{4'd0, 2'd0, 1'b0, 1'b0, 1'b0, FULL_LEFT - 6'd1}},
            '{CMD_REMOVE,  4'd15, 2'd3, 31'd0,        1'b1,
              '{4'd0, 2'd0, 1'b0, 1'b0, 1'b0, FULL_LEFT - 6'd1}},
            '{CMD_REMOVE,  4'd0,  2'd0, 31'd0,        1'b1,
              '{4'd0, 2'd0, 1'b1, 1'b0, 1'b0, FULL_LEFT - 6'd2}},
            '{CMD_DRAW,    4'd0,  2'd0, 31'd0,        1'b0, '0},
            '{CMD_SHUFFLE, 4'd0,  2'd0, WORD_ONES,    1'b0, '0},
            '{CMD_SHUFFLE, 4'd0,  2'd0, 31'd0,        1'b0, '0},
            '{CMD_INIT,    4'd0,  2'd0, 31'd0,        1'b1,
              '{4'd0, 2'd0, 1'b0, 1'b0, 1'b0, FULL_LEFT}},
            '{CMD_SHUFFLE, 4'd0,  2'd0, 31'h2AAAAAAA, 1'b0, '0},
            '{CMD_REMOVE,  4'd0,  2'd1, 31'd0,        1'b1,
              '{4'd0, 2'd0, 1'b1, 1'b0, 1'b0, FULL_LEFT - 6'd1}},
            '{CMD_REMOVE,  4'd0,  2'd2, 31'd0,        1'b1,
              '{4'd0, 2'd0, 1'b1, 1'b0, 1'b0, FULL_LEFT - 6'd2}},
            '{CMD_SHUFFLE, 4'd0,  2'd0, 31'h55555555, 1'b0, '0},
            '{CMD_DRAW,    4'd0,  2'd0, 31'd0,        1'b0, '0},
            '{CMD_REMOVE,  4'd13, 2'd0, 31'd0,        1'b1,
              '{4'd0, 2'd0, 1'b0, 1'b0, 1'b0, FULL_LEFT - 6'd2}},
            '{CMD_INIT,    4'd0,  2'd0, 31'd0,        1'b1,
              '{4'd0, 2'd0, 1'b0, 1'b0, 1'b0, FULL_LEFT}}
        };

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
            send_item(directed_rows[i].cmd, directed_rows[i].rank, directed_rows[i].suit,
                      directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);

        // hold off until the table has answered everything so far
        wait_quiet();
        run_random();

        @(negedge clk);
        req_if.valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run: %0d items driven, %0d results checked, %0d mismatching fields",
                 items_sent, results_seen, errors);
        $display("run: %0d removals hit, %0d shuffle passes closed, %0d draws on empty deck",
                 remove_hits, passes_closed, empty_draws);
        if (errors == 0 && pending_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[files.f]
hw/rtl/cdpt_pkg.sv
hw/rtl/cdpt_if.sv
hw/rtl/cdpt_ram.sv
hw/rtl/cdpt_mod.sv
hw/rtl/card_deck_permutation_table.sv
verif/testbench.sv
